[rtl/aafc_pkg.sv]
// Shared types and constants for the box-against-frustum culling block.
// Holds the fixed-point widths, the box and result payloads and the beat passed
// between cells. Depends on nothing.
`default_nettype none

package aafc_pkg;

    localparam int NUM_PLANES     = 6;
    localparam int COORD_BITS     = 16;
    localparam int COEF_FRAC_BITS = 14;

    localparam int SLOT_BITS    = 16;
    localparam int PLANE_BITS   = 4 * SLOT_BITS;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_BITS     = PLANE_BITS;

    localparam int COEF_BITS = COEF_FRAC_BITS + 2;
    localparam int HALF_BITS = COORD_BITS - 1;
    localparam int PROD_BITS = COORD_BITS + COEF_BITS;
    localparam int RAD_BITS  = HALF_BITS + COEF_BITS;
    localparam int OFS_BITS  = SLOT_BITS + COEF_FRAC_BITS;
    localparam int ACC_BITS  = ((PROD_BITS > OFS_BITS) ? PROD_BITS : OFS_BITS) + 4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic        [HALF_BITS-1:0]  half_x;
        logic        [HALF_BITS-1:0]  half_y;
        logic        [HALF_BITS-1:0]  half_z;
    } box_t;

    typedef struct packed {
        logic                  visible;
        logic [NUM_PLANES-1:0] outside_mask;
    } result_t;

    // One box travelling down the row of cells with the planes' verdicts so far.
    typedef struct packed {
        logic                  valid;
        box_t                  box;
        logic [NUM_PLANES-1:0] mask;
    } beat_t;

endpackage

`default_nettype wire

[rtl/aafc_cell.sv]
// One culling cell: tests the passing box against one plane in three stages.
// Depends on aafc_pkg for the widths and the beat type.
`default_nettype none

module aafc_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [aafc_pkg::PLANE_BITS-1:0]  plane,
    input  aafc_pkg::beat_t                  up,
    output logic                             up_ready,
    output aafc_pkg::beat_t                  dn,
    input  logic                             dn_ready
);

    localparam int CB = aafc_pkg::COORD_BITS;
    localparam int HB = aafc_pkg::HALF_BITS;
    localparam int NB = aafc_pkg::COEF_BITS;
    localparam int PB = aafc_pkg::PROD_BITS;
    localparam int RB = aafc_pkg::RAD_BITS;
    localparam int OB = aafc_pkg::OFS_BITS;
    localparam int AB = aafc_pkg::ACC_BITS;
    localparam int SB = aafc_pkg::SLOT_BITS;
    localparam int NP = aafc_pkg::NUM_PLANES;

    logic signed [CB-1:0] coord [3];
    logic        [HB-1:0] half  [3];
    logic signed [NB-1:0] coef  [3];
    logic signed [PB-1:0] prod_next [3];
    logic        [RB-1:0] rad_next  [3];
    logic signed [OB-1:0] ofs_next;

    logic                   v1_reg, v2_reg, v3_reg;
    logic                   rdy1, rdy2, rdy3;
    aafc_pkg::box_t         box1_reg, box2_reg, box3_reg;
    logic [NP-1:0]          mask1_reg, mask2_reg, mask3_reg;
    logic [NP-1:0]          mask3_next;
    logic signed [PB-1:0]   prod_reg [3];
    logic        [RB-1:0]   rad_reg  [3];
    logic signed [OB-1:0]   ofs_reg;
    logic signed [AB-1:0]   sum_a_reg, sum_b_reg, sum_c_reg, sum_d_reg;
    logic signed [AB-1:0]   sum_a_next, sum_b_next, sum_c_next, sum_d_next;
    logic signed [AB-1:0]   total;

    assign coord[0] = up.box.center_x;
    assign coord[1] = up.box.center_y;
    assign coord[2] = up.box.center_z;
    assign half[0]  = up.box.half_x;
    assign half[1]  = up.box.half_y;
    assign half[2]  = up.box.half_z;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic signed [PB-1:0] c_ext;
        logic signed [PB-1:0] n_ext;
        logic        [NB-1:0] n_mag;
        logic        [RB-1:0] h_ext;
        logic        [RB-1:0] m_ext;

        // Each coefficient takes the whole of its slot.
        assign coef[k]      = plane[k*SB +: NB];
        assign c_ext        = PB'(coord[k]);
        assign n_ext        = PB'(coef[k]);
        assign n_mag        = coef[k][NB-1] ? NB'(-n_ext) : NB'(n_ext);
        assign h_ext        = RB'(half[k]);
        assign m_ext        = RB'(n_mag);
        assign prod_next[k] = c_ext * n_ext;
        assign rad_next[k]  = h_ext * m_ext;
    end

    // The offset is brought to the product scale by appending fraction zeros.
    assign ofs_next = {plane[3*SB +: SB], {aafc_pkg::COEF_FRAC_BITS{1'b0}}};

    assign rdy3     = !v3_reg || dn_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign up_ready = rdy1;

    assign sum_a_next = AB'(prod_reg[0]) + AB'(prod_reg[1]);
    assign sum_b_next = AB'(prod_reg[2]) + AB'(ofs_reg);
    assign sum_c_next = $signed(AB'(rad_reg[0])) + $signed(AB'(rad_reg[1]));
    assign sum_d_next = $signed(AB'(rad_reg[2]));

    assign total = (sum_a_reg + sum_b_reg) + (sum_c_reg + sum_d_reg);

    // Each cell shifts the verdicts down by one and enters its own at the top,
    // so the first cell's verdict ends in bit zero.
    always_comb
    begin
        mask3_next         = mask2_reg >> 1;
        mask3_next[NP-1]   = total[AB-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= up.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && up.valid)
        begin
            box1_reg  <= up.box;
            mask1_reg <= up.mask;
            prod_reg  <= prod_next;
            rad_reg   <= rad_next;
            ofs_reg   <= ofs_next;
        end
        if (rdy2 && v1_reg)
        begin
            box2_reg  <= box1_reg;
            mask2_reg <= mask1_reg;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            sum_c_reg <= sum_c_next;
            sum_d_reg <= sum_d_next;
        end
        if (rdy3 && v2_reg)
        begin
            box3_reg  <= box2_reg;
            mask3_reg <= mask3_next;
        end
    end

    assign dn.valid = v3_reg;
    assign dn.box   = box3_reg;
    assign dn.mask  = mask3_reg;

endmodule

`default_nettype wire

[rtl/aabb_frustum_cull_test_top.sv]
// Top level of the box-against-frustum culling block: plane registers, the row
// of culling cells and the result register. Depends on aafc_pkg and aafc_cell.
`default_nettype none

// Usage
// A box beat (centre and half extents) is taken on the box channel whenever
// box_valid and box_ready are both high. Each box flows down a row of cells,
// one cell per frustum plane; a cell holds one plane, registers its products,
// then its partial sums, then its final sum and sign, and hands the box on to its
// neighbour together with the verdicts gathered so far.
// A result beat reaches the result channel after the box has passed the cells'
// stages and then the result register. While the receiver does not stall, one
// box is taken in every cycle, so results stream at one per cycle; the fully
// pipelined cells allow this.
// The plane registers are written on the configuration channel, which is always
// ready; an index at or beyond the number of planes is ignored. Planes are to be
// written only while no box is in flight.
// Reset clears every plane to zero, which rejects nothing, and empties the row.
// When the receiver stalls, the result register holds its beat and each stage
// keeps taking beats until it is full, so boxes are still accepted until
// every stage of the row holds one.
module aabb_frustum_cull_test_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                box_valid,
    output logic                                box_ready,
    input  aafc_pkg::box_t                      box_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output aafc_pkg::result_t                   result_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aafc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [aafc_pkg::CFG_BITS-1:0]       cfg_data
);

    localparam int NP = aafc_pkg::NUM_PLANES;

    logic [aafc_pkg::PLANE_BITS-1:0] plane_reg [NP];
    aafc_pkg::beat_t                 link       [NP+1];
    logic                            ready_link [NP+1];
    logic                            result_valid_reg;
    aafc_pkg::result_t               result_data_reg;

    // Configuration is taken in every cycle.
    assign cfg_ready = 1'b1;

    for (genvar i = 0; i < NP; i++) begin : g_plane
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                plane_reg[i] <= '0;
            end
            else if (cfg_valid && cfg_index == aafc_pkg::CFG_IDX_BITS'(i))
            begin
                plane_reg[i] <= cfg_data;
            end
        end
    end

    // The incoming box enters the first cell with no verdicts yet.
    assign link[0].valid = box_valid;
    assign link[0].box   = box_data;
    assign link[0].mask  = '0;
    assign box_ready     = ready_link[0];

    for (genvar i = 0; i < NP; i++) begin : g_cell
        aafc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .plane    (plane_reg[i]),
            .up       (link[i]),
            .up_ready (ready_link[i]),
            .dn       (link[i+1]),
            .dn_ready (ready_link[i+1])
        );
    end

    // The result register parts the row from the receiver.
    assign ready_link[NP] = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ready_link[NP])
        begin
            result_valid_reg <= link[NP].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_link[NP] && link[NP].valid)
        begin
            result_data_reg.visible      <= (link[NP].mask == '0);
            result_data_reg.outside_mask <= link[NP].mask;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

`ifndef SYNTH
    // A result says visible exactly when no plane rejected the box.
    a_visible_matches_mask : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.visible == (result_data.outside_mask == '0)))
        else $error("visible flag disagrees with the outside mask");

    // With the result register empty every stage can move, so boxes are taken.
    a_ready_when_drained : assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> box_ready)
        else $error("box channel stalled although the result register is empty");

    // A waiting result beat is never overwritten.
    a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_data)))
        else $error("stalled result beat changed");
`endif

endmodule

`default_nettype wire

[dv/cull_scoreboard_pkg.sv]
// Scoreboard for the box-against-frustum culling testbench: a bit-exact predictor
// of the verdicts, the queue of verdicts still awaited, and the plane register names.
// Depends on aafc_pkg for the payload types and widths.
package cull_scoreboard_pkg;

    import aafc_pkg::*;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PLANE_LEFT,
        REG_PLANE_RIGHT,
        REG_PLANE_TOP,
        REG_PLANE_BOTTOM,
        REG_PLANE_NEAR,
        REG_PLANE_FAR,
        REG_SPARE_6,
        REG_SPARE_7
    } plane_reg_e;

    class cull_scoreboard;

        logic [PLANE_BITS-1:0] planes [NUM_PLANES];
        result_t               pending_verdicts [$];
        int                    mismatches;

        function new();
            foreach (planes[i])
            begin
                planes[i] = '0;
            end
            mismatches = 0;
        endfunction

        // Writes to indexes beyond the last plane are dropped by the block.
        function void set_plane(logic [CFG_IDX_BITS-1:0] idx, logic [PLANE_BITS-1:0] value);
            if (idx < NUM_PLANES)
            begin
                planes[idx] = value;
            end
        endfunction

        // Exact integer evaluation of s + r for every plane; a plane rejects the box
        // only when the sum is strictly negative.
        function result_t cull_verdict(box_t b);
            longint                centre [3];
            longint                half [3];
            longint                coef;
            longint                plane_dist;
            longint                radius;
            logic [PLANE_BITS-1:0] p;
            logic [NUM_PLANES-1:0] mask;
            result_t               verdict;
            centre[0] = longint'($signed(b.center_x));
            centre[1] = longint'($signed(b.center_y));
            centre[2] = longint'($signed(b.center_z));
            half[0]   = longint'(b.half_x);
            half[1]   = longint'(b.half_y);
            half[2]   = longint'(b.half_z);
            mask      = '0;
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                p          = planes[i];
                plane_dist = longint'($signed(p[3*SLOT_BITS +: SLOT_BITS]))
                             * (longint'(1) << COEF_FRAC_BITS);
                radius     = 0;
                for (int k = 0; k < 3; k++)
                begin
                    coef        = longint'($signed(p[k*SLOT_BITS +: COEF_BITS]));
                    plane_dist += centre[k] * coef;
                    radius     += half[k] * ((coef < 0) ? -coef : coef);
                end
                mask[i] = (plane_dist + radius < 0);
            end
            verdict.visible      = (mask == '0);
            verdict.outside_mask = mask;
            return verdict;
        endfunction

        function void note_box(box_t b);
            pending_verdicts.push_back(cull_verdict(b));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("cull check: result beat with nothing awaited, visible=%0b mask=%b",
                             got.visible, got.outside_mask);
                end
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.visible !== want.visible || got.outside_mask !== want.outside_mask)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("cull check at %0t: expected visible=%0b mask=%b, got visible=%0b mask=%b",
                                 $realtime, want.visible, want.outside_mask,
                                 got.visible, got.outside_mask);
                    end
                end
            end
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

    endclass

endpackage

[dv/tb_aabb_frustum_cull_test_top.sv]
// Self-checking testbench for the box-against-frustum culling block.
// Streams boxes under several plane settings with random sender gaps and receiver
// stalls, and checks every result beat. Depends on aafc_pkg and cull_scoreboard_pkg.
module tb_aabb_frustum_cull_test_top;

    timeunit 1ns;
    timeprecision 1ps;

    import aafc_pkg::*;
    import cull_scoreboard_pkg::*;

    // The quiet period at the end allows for the block's latency and a margin, so
    // that any stray late beat is still caught.
    localparam int LATENCY_CYCLES   = 3 * NUM_PLANES + 1;
    localparam int SETTLE_CYCLES    = LATENCY_CYCLES + 20;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int BOXES_PER_PHASE  = 260;

    // Q1.14 unit normal coefficient.
    localparam int COEF_ONE = 1 << COEF_FRAC_BITS;

    // Plane settings that the run steps through.
    typedef enum int {
        FR_ZERO,
        FR_BOX_VIEW,
        FR_RANDOM,
        FR_TILTED,
        FR_EXTREME,
        FR_SPARSE
    } frustum_e;

    logic                    clk;
    logic                    rst_n;
    logic                    box_valid;
    logic                    box_ready;
    box_t                    box_data;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    result_t                 result_data;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    cull_scoreboard cull_sb;
    int             cycle_count = 0;
    int             burst_left  = 0;
    int             ready_left  = 0;
    int             stall_left  = 0;

    aabb_frustum_cull_test_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .box_valid    (box_valid),
        .box_ready    (box_ready),
        .box_data     (box_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost beat ends the run here rather than
    // letting it spin for ever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("aabb_frustum_cull_test_top: mismatch");
            $finish;
        end
    end

    // All handshakes are observed at the rising edge. Inputs only ever change on the
    // falling edge, so the values seen here are settled. A configuration beat
    // updates the predictor's planes, a box beat queues its verdict, and a result
    // beat is checked against the oldest verdict still awaited.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cull_sb.set_plane(cfg_index, cfg_data);
            end
            if (box_valid && box_ready)
            begin
                cull_sb.note_box(box_data);
            end
            if (result_valid && result_ready)
            begin
                cull_sb.check_result(result_data);
            end
        end
    end

    // Receiver back-pressure. The receiver alternates runs of readiness with stalls
    // of its own choosing: most stalls are short, a few are long enough to fill the
    // whole row of cells, and about a third of the runs carry no stall at all.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready = 1'b0;
            stall_left--;
        end
        else if (ready_left > 0)
        begin
            result_ready = 1'b1;
            ready_left--;
        end
        else
        begin
            ready_left   = $urandom_range(1, 40);
            stall_left   = ($urandom_range(0, 2) == 0) ? 0 :
                           ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) :
                                                         $urandom_range(1, 4);
            result_ready = 1'b1;
        end
    end

    function automatic logic [PLANE_BITS-1:0] pack_plane(int nx, int ny, int nz, int w);
        return {w[SLOT_BITS-1:0], nz[SLOT_BITS-1:0], ny[SLOT_BITS-1:0], nx[SLOT_BITS-1:0]};
    endfunction

    function automatic box_t make_box(int cx, int cy, int cz, int hx, int hy, int hz);
        box_t b;
        b.center_x = cx[COORD_BITS-1:0];
        b.center_y = cy[COORD_BITS-1:0];
        b.center_z = cz[COORD_BITS-1:0];
        b.half_x   = hx[HALF_BITS-1:0];
        b.half_y   = hy[HALF_BITS-1:0];
        b.half_z   = hz[HALF_BITS-1:0];
        return b;
    endfunction

    // Picks the low or the high end of a field's range, zero, or a random value within it.
    function automatic int edge_value(int lo, int hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            2:       return 0;
            default: return $urandom_range(0, hi - lo) + lo;
        endcase
    endfunction

    // Random boxes come in three flavours: fully random bits (which exercise every
    // bit of every field), boxes scattered around the view volume with modest
    // extents (which straddle the planes and give mixed verdicts), and boxes whose
    // fields sit at the ends of their ranges.
    function automatic box_t rand_box();
        int          sel;
        int unsigned r0;
        int unsigned r1;
        int unsigned r2;
        box_t        b;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            r0 = $urandom;
            r1 = $urandom;
            r2 = $urandom;
            b.center_x = r0[15:0];
            b.center_y = r0[31:16];
            b.center_z = r1[15:0];
            b.half_x   = r1[30:16];
            b.half_y   = r2[14:0];
            b.half_z   = r2[30:16];
        end
        else if (sel < 9)
        begin
            b = make_box(int'($urandom_range(0, 6000)) - 3000,
                         int'($urandom_range(0, 6000)) - 3000,
                         int'($urandom_range(0, 9000)) - 2000,
                         $urandom_range(0, 800), $urandom_range(0, 800),
                         $urandom_range(0, 800));
        end
        else
        begin
            b = make_box(edge_value(-32768, 32767), edge_value(-32768, 32767),
                         edge_value(-32768, 32767), edge_value(0, 32767),
                         edge_value(0, 32767), edge_value(0, 32767));
        end
        return b;
    endfunction

    // Presents one box beat and holds it until it is taken. The sender works in
    // bursts: when a burst runs out, valid drops for a random gap (usually short,
    // now and then long) before the next burst starts. Within a burst valid stays
    // high and only the payload moves on.
    task automatic send_box(box_t b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                box_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        box_data  = b;
        box_valid = 1'b1;
        do
            @(posedge clk);
        while (!box_ready);
        @(negedge clk);
        burst_left--;
    endtask

    // Holds the sender off until every verdict awaited has come back, so that the
    // row of cells is empty.
    task automatic wait_drain();
        box_valid  = 1'b0;
        burst_left = 0;
        while (cull_sb.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(plane_reg_e idx, logic [CFG_BITS-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Loads a whole plane setting. The row is drained first, since planes may only
    // change while no box is in flight. Each setting also writes one of the two
    // unused indexes with random data, which the block must ignore.
    task automatic program_frustum(frustum_e kind);
        logic [PLANE_BITS-1:0] plane_val;
        wait_drain();
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            case (kind)
                FR_ZERO:
                    plane_val = '0;
                // A box-shaped view volume with inward normals:
                // -1000 <= x <= 1000, -800 <= y <= 800, 16 <= z <= 4000.
                FR_BOX_VIEW:
                    case (plane_reg_e'(i))
                        REG_PLANE_LEFT:   plane_val = pack_plane(COEF_ONE, 0, 0, 1000);
                        REG_PLANE_RIGHT:  plane_val = pack_plane(-COEF_ONE, 0, 0, 1000);
                        REG_PLANE_TOP:    plane_val = pack_plane(0, -COEF_ONE, 0, 800);
                        REG_PLANE_BOTTOM: plane_val = pack_plane(0, COEF_ONE, 0, 800);
                        REG_PLANE_NEAR:   plane_val = pack_plane(0, 0, COEF_ONE, -16);
                        default:          plane_val = pack_plane(0, 0, -COEF_ONE, 4000);
                    endcase
                FR_RANDOM:
                    plane_val = {$urandom, $urandom};
                // Oblique planes with coefficients of at most unit size and offsets
                // of the order of the box positions, so verdicts come out mixed.
                FR_TILTED:
                    plane_val = pack_plane(int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE,
                                           int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE,
                                           int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE,
                                           int'($urandom_range(0, 5000)) - 1000);
                // Coefficients and offsets at the ends of their ranges.
                FR_EXTREME:
                    case (plane_reg_e'(i))
                        REG_PLANE_LEFT:   plane_val = {4{16'h7FFF}};
                        REG_PLANE_RIGHT:  plane_val = {4{16'h8000}};
                        REG_PLANE_TOP:    plane_val = '1;
                        REG_PLANE_BOTTOM: plane_val = {16'h7FFF, {3{16'h8000}}};
                        REG_PLANE_NEAR:   plane_val = {16'h8000, {3{16'h7FFF}}};
                        default:          plane_val = {16'h8000, 16'h0000, 16'h0000, 16'h7FFF};
                    endcase
                default:
                    plane_val = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
            endcase
            write_reg(plane_reg_e'(i), plane_val);
        end
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
    endtask

    initial
    begin
        frustum_e phase_order [5];
        phase_order = '{FR_BOX_VIEW, FR_RANDOM, FR_TILTED, FR_EXTREME, FR_SPARSE};
        cull_sb   = new();
        rst_n     = 1'b0;
        box_valid = 1'b0;
        box_data  = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_PLANE_LEFT;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Straight out of reset every plane is zero, so nothing may be rejected,
        // not even boxes at the corners of the coordinate range.
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(32767, 32767, 32767, 0, 0, 0));

        // Directed boxes against the box-shaped view volume. For each plane a box
        // that just touches it from outside (s + r exactly zero, so kept) is
        // followed by one a single step further out (rejected).
        program_frustum(FR_BOX_VIEW);
        send_box(make_box(0, 0, 1000, 10, 10, 10));
        send_box(make_box(-1500, 0, 1000, 500, 10, 10));
        send_box(make_box(-1500, 0, 1000, 499, 10, 10));
        send_box(make_box(1500, 0, 1000, 500, 10, 10));
        send_box(make_box(1500, 0, 1000, 499, 10, 10));
        send_box(make_box(0, 1300, 1000, 10, 500, 10));
        send_box(make_box(0, 1300, 1000, 10, 499, 10));
        send_box(make_box(0, -1300, 1000, 10, 500, 10));
        send_box(make_box(0, -1300, 1000, 10, 499, 10));
        send_box(make_box(0, 0, -484, 10, 10, 500));
        send_box(make_box(0, 0, -484, 10, 10, 499));
        send_box(make_box(0, 0, 4500, 10, 10, 500));
        send_box(make_box(0, 0, 4500, 10, 10, 499));
        // A zero-extent box tests the centre point alone: the origin lies just
        // behind the near plane, while z = 16 sits exactly on it.
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(0, 0, 16, 0, 0, 0));
        // Extreme centres and extents, with several planes rejecting at once.
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(32767, 32767, 32767, 0, 0, 0));
        send_box(make_box(-32768, -32768, -32768, 0, 0, 0));

        // Random boxes under each plane setting in turn. Halfway through the first
        // setting the sender holds off until the row has emptied completely.
        foreach (phase_order[p])
        begin
            program_frustum(phase_order[p]);
            for (int n = 0; n < BOXES_PER_PHASE; n++)
            begin
                if (p == 0 && n == BOXES_PER_PHASE / 2)
                begin
                    wait_drain();
                end
                send_box(rand_box());
            end
        end

        // Back to all-zero planes for a short closing stretch.
        program_frustum(FR_ZERO);
        for (int n = 0; n < 20; n++)
        begin
            send_box(rand_box());
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (cull_sb.mismatches == 0 && cull_sb.pending() == 0)
        begin
            $display("aabb_frustum_cull_test_top: match");
        end
        else
        begin
            $display("aabb_frustum_cull_test_top: mismatch");
        end
        $finish;
    end

endmodule
